/* design/gcb_pkg.sv */
// Shared constants, register codes and the gamma lookup contents of the glyph blender.
package gcb_pkg;

   localparam int DEFAULT_MAX_PITCH = 4096;
   localparam int DEFAULT_MAX_GLYPH = 256;

   localparam int COV_W       = 8;
   localparam int CH_W        = 8;
   localparam int CHANNELS    = 3;
   localparam int RGB_W       = CH_W * CHANNELS;
   localparam int PIXEL_W     = 32;
   localparam int ADDR_W      = 24;
   localparam int SIZE_W      = 13;
   localparam int GSIZE_W     = 9;
   localparam int BLEND_W     = 2 * CH_W;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [COV_W-1:0] COV_EMPTY    = 8'h00;
   localparam logic [COV_W-1:0] COV_FULL     = 8'hff;
   localparam logic [CH_W-1:0]  CH_MAX       = 8'hff;
   localparam logic [CH_W-1:0]  ALPHA_OPAQUE = 8'hff;

   localparam logic [SIZE_W-1:0]  LINE_PITCH_RESET    = 13'd1024;
   localparam logic [SIZE_W-1:0]  BUFFER_HEIGHT_RESET = 13'd768;
   localparam logic [GSIZE_W-1:0] GLYPH_SIZE_RESET    = 9'd1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FG_COLOR      = 3'd0,
      CSR_BG_COLOR      = 3'd1,
      CSR_LINE_PITCH    = 3'd2,
      CSR_BUFFER_HEIGHT = 3'd3,
      CSR_ORIGIN_X      = 3'd4,
      CSR_ORIGIN_Y      = 3'd5,
      CSR_GLYPH_WIDTH   = 3'd6,
      CSR_GLYPH_ROWS    = 3'd7
   } csr_index_type;

   // Placement of the current coverage byte within the glyph and the buffer.
   typedef struct packed {
      logic in_bounds;
      logic last;
   } place_type;

   typedef logic [CH_W-1:0] gamma_table_type [256];

   // Step sizes of the gamma curve in sixteenths, one per group of 16 codes.
   localparam int GAMMA_CURVE [16] = '{5, 6, 7, 8, 9, 10, 11, 12,
                                      14, 16, 18, 20, 23, 27, 32, 39};

   // Walks down from the top code, subtracting the curve step of each group.
   function automatic gamma_table_type build_gamma();
      gamma_table_type rom;
      int acc;
      acc = 4088;
      for (int i = 255; i >= 0; i--) begin
         rom[i] = CH_W'(acc >> 4);
         acc = acc - GAMMA_CURVE[(255 - i) >> 4];
      end
      return rom;
   endfunction

   localparam gamma_table_type GAMMA_ROM = build_gamma();

endpackage

/* design/glyph_coverage_blend.sv */
// Top level of the glyph blender: configuration registers and the three-stage pixel pipeline.
//
// Coverage bytes of one glyph enter on the req_ channel in row-major order,
// one per beat. Every beat produces exactly one beat on the rsp_ channel: a
// framebuffer write (rsp_write_enable high, with word address and ARGB value)
// or a no-write beat whose address and value are zero. rsp_last marks the
// glyph's final byte. Writes are suppressed for a glyph that does not fit
// inside the buffer; the position counters still advance.
// An accepted request beat is registered through the stages (gamma lookup,
// address multiply plus channel products, rounding divide) to its response
// beat; throughput is one beat per cycle while rsp_stall is low.
// The csr_ port writes one register per cycle at csr_index; it is to be used only
// while the pipeline is empty; the block itself does not enforce this.
// Reset clears the pipeline, the glyph counters and the registers to their
// defaults (pitch 1024, height 768, glyph 1 by 1, colors and origin zero).
// When rsp_stall is high the output holds; empty stages upstream keep
// filling, and req_stall rises only once every stage is occupied.
module glyph_coverage_blend #(
   parameter int MAX_PITCH = gcb_pkg::DEFAULT_MAX_PITCH,
   parameter int MAX_GLYPH = gcb_pkg::DEFAULT_MAX_GLYPH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [gcb_pkg::COV_W-1:0]        req_coverage,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_write_enable,
   output logic [gcb_pkg::ADDR_W-1:0]       rsp_pixel_address,
   output logic [gcb_pkg::PIXEL_W-1:0]      rsp_pixel_value,
   output logic                             rsp_last,
   input  logic                             csr_write,
   input  logic [gcb_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [gcb_pkg::CSR_DATA_W-1:0]   csr_data
);
   import gcb_pkg::*;

   localparam int PITCH_W = $clog2(MAX_PITCH + 1);
   localparam int POS_W   = $clog2(MAX_PITCH + MAX_GLYPH);
   localparam int LINE_W  = POS_W + PITCH_W;
   localparam int SUM_W   = ((LINE_W > ADDR_W) ? LINE_W : ADDR_W) + 1;

   // Configuration registers.
   logic [PIXEL_W-1:0] fg_color_ff, fg_color_in;
   logic [RGB_W-1:0]   bg_color_ff, bg_color_in;
   logic [SIZE_W-1:0]  line_pitch_ff, line_pitch_in;
   logic [SIZE_W-1:0]  buffer_height_ff, buffer_height_in;
   logic [SIZE_W-1:0]  origin_x_ff, origin_x_in;
   logic [SIZE_W-1:0]  origin_y_ff, origin_y_in;
   logic [GSIZE_W-1:0] glyph_width_ff, glyph_width_in;
   logic [GSIZE_W-1:0] glyph_rows_ff, glyph_rows_in;

   // Pipeline control.
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic s3_valid_ff, s3_valid_in;
   logic s1_ready, s2_ready, s3_ready;
   logic accept, load_s2, load_s3;

   // Stage payloads.
   logic               s1_write_ff, s1_full_ff, s1_last_ff;
   logic [CH_W-1:0]    s1_gamma_ff;
   logic [POS_W-1:0]   s1_row_ff, s1_col_ff;
   logic               s2_write_ff, s2_full_ff, s2_last_ff;
   logic [ADDR_W-1:0]  s2_address_ff, s2_address_in;
   logic               s3_write_ff, s3_last_ff;
   logic [ADDR_W-1:0]  s3_address_ff, s3_address_in;
   logic [PIXEL_W-1:0] s3_value_ff, s3_value_in;

   logic [PITCH_W-1:0] pitch;
   logic [POS_W-1:0]   row_pos, col_pos;
   place_type          place;
   logic [LINE_W-1:0]  line_base;
   logic [SUM_W-1:0]   address_sum;
   logic [RGB_W-1:0]   blend_rgb;

   always_comb begin
      fg_color_in      = fg_color_ff;
      bg_color_in      = bg_color_ff;
      line_pitch_in    = line_pitch_ff;
      buffer_height_in = buffer_height_ff;
      origin_x_in      = origin_x_ff;
      origin_y_in      = origin_y_ff;
      glyph_width_in   = glyph_width_ff;
      glyph_rows_in    = glyph_rows_ff;
      if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_FG_COLOR:      fg_color_in      = csr_data;
            CSR_BG_COLOR:      bg_color_in      = csr_data[RGB_W-1:0];
            CSR_LINE_PITCH:    line_pitch_in    = csr_data[SIZE_W-1:0];
            CSR_BUFFER_HEIGHT: buffer_height_in = csr_data[SIZE_W-1:0];
            CSR_ORIGIN_X:      origin_x_in      = csr_data[SIZE_W-1:0];
            CSR_ORIGIN_Y:      origin_y_in      = csr_data[SIZE_W-1:0];
            CSR_GLYPH_WIDTH:   glyph_width_in   = csr_data[GSIZE_W-1:0];
            CSR_GLYPH_ROWS:    glyph_rows_in    = csr_data[GSIZE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fg_color_ff      <= '0;
         bg_color_ff      <= '0;
         line_pitch_ff    <= LINE_PITCH_RESET;
         buffer_height_ff <= BUFFER_HEIGHT_RESET;
         origin_x_ff      <= '0;
         origin_y_ff      <= '0;
         glyph_width_ff   <= GLYPH_SIZE_RESET;
         glyph_rows_ff    <= GLYPH_SIZE_RESET;
      end else begin
         fg_color_ff      <= fg_color_in;
         bg_color_ff      <= bg_color_in;
         line_pitch_ff    <= line_pitch_in;
         buffer_height_ff <= buffer_height_in;
         origin_x_ff      <= origin_x_in;
         origin_y_ff      <= origin_y_in;
         glyph_width_ff   <= glyph_width_in;
         glyph_rows_ff    <= glyph_rows_in;
      end
   end

   // A stage can take a new beat when it is empty or its content moves on.
   assign s3_ready  = !s3_valid_ff || !rsp_stall;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_stall = !s1_ready;
   assign accept    = req_valid && s1_ready;
   assign load_s2   = s1_valid_ff && s2_ready;
   assign load_s3   = s2_valid_ff && s3_ready;

   assign s1_valid_in = s1_ready ? req_valid : s1_valid_ff;
   assign s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in = s3_ready ? s2_valid_ff : s3_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   gcb_locate #(
      .MAX_PITCH (MAX_PITCH),
      .MAX_GLYPH (MAX_GLYPH)
   ) u_locate (
      .clock         (clock),
      .reset         (reset),
      .advance       (accept),
      .line_pitch    (line_pitch_ff),
      .buffer_height (buffer_height_ff),
      .origin_x      (origin_x_ff),
      .origin_y      (origin_y_ff),
      .glyph_width   (glyph_width_ff),
      .glyph_rows    (glyph_rows_ff),
      .pitch         (pitch),
      .row_pos       (row_pos),
      .col_pos       (col_pos),
      .place         (place)
   );

   // Stage 1: classify the coverage and look up its gamma value.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_write_ff <= place.in_bounds && (req_coverage != COV_EMPTY);
         s1_full_ff  <= req_coverage == COV_FULL;
         s1_last_ff  <= place.last;
         s1_gamma_ff <= GAMMA_ROM[req_coverage];
         s1_row_ff   <= row_pos;
         s1_col_ff   <= col_pos;
      end
   end

   // Stage 2: word address and the channel products.
   assign line_base     = LINE_W'(s1_row_ff) * LINE_W'(pitch);
   assign address_sum   = SUM_W'(line_base) + SUM_W'(s1_col_ff);
   assign s2_address_in = address_sum[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (load_s2) begin
         s2_write_ff   <= s1_write_ff;
         s2_full_ff    <= s1_full_ff;
         s2_last_ff    <= s1_last_ff;
         s2_address_ff <= s2_address_in;
      end
   end

   gcb_blend u_blend (
      .clock  (clock),
      .load   (load_s2),
      .gamma  (s1_gamma_ff),
      .fg_rgb (fg_color_ff[RGB_W-1:0]),
      .bg_rgb (bg_color_ff),
      .rgb    (blend_rgb)
   );

   // Stage 3: output register; a beat without a write carries zeros.
   assign s3_address_in = s2_write_ff ? s2_address_ff : '0;
   assign s3_value_in   = !s2_write_ff ? '0 :
                          s2_full_ff ? fg_color_ff : {ALPHA_OPAQUE, blend_rgb};

   always_ff @(posedge clock) begin
      if (load_s3) begin
         s3_write_ff   <= s2_write_ff;
         s3_last_ff    <= s2_last_ff;
         s3_address_ff <= s3_address_in;
         s3_value_ff   <= s3_value_in;
      end
   end

   assign rsp_valid         = s3_valid_ff;
   assign rsp_write_enable  = s3_write_ff;
   assign rsp_pixel_address = s3_address_ff;
   assign rsp_pixel_value   = s3_value_ff;
   assign rsp_last          = s3_last_ff;

endmodule

/* design/gcb_locate.sv */
// Glyph column and row counters, size clamping and the buffer bounds check.
module gcb_locate #(
   parameter int MAX_PITCH = gcb_pkg::DEFAULT_MAX_PITCH,
   parameter int MAX_GLYPH = gcb_pkg::DEFAULT_MAX_GLYPH
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        advance,
   input  logic [gcb_pkg::SIZE_W-1:0]                  line_pitch,
   input  logic [gcb_pkg::SIZE_W-1:0]                  buffer_height,
   input  logic [gcb_pkg::SIZE_W-1:0]                  origin_x,
   input  logic [gcb_pkg::SIZE_W-1:0]                  origin_y,
   input  logic [gcb_pkg::GSIZE_W-1:0]                 glyph_width,
   input  logic [gcb_pkg::GSIZE_W-1:0]                 glyph_rows,
   output logic [$clog2(MAX_PITCH + 1)-1:0]            pitch,
   output logic [$clog2(MAX_PITCH + MAX_GLYPH)-1:0]    row_pos,
   output logic [$clog2(MAX_PITCH + MAX_GLYPH)-1:0]    col_pos,
   output gcb_pkg::place_type                          place
);
   import gcb_pkg::*;

   localparam int PITCH_W = $clog2(MAX_PITCH + 1);
   // Counters left over from a larger glyph can carry a position past the pitch.
   localparam int POS_W   = $clog2(MAX_PITCH + MAX_GLYPH);
   localparam int GLYPH_W = $clog2(MAX_GLYPH + 1);
   localparam int CNT_W   = $clog2(MAX_GLYPH);
   localparam int PC_W    = (PITCH_W > SIZE_W) ? PITCH_W : SIZE_W;
   localparam int GC_W    = (GLYPH_W > GSIZE_W) ? GLYPH_W : GSIZE_W;
   localparam int BND_W   = ((PC_W > GC_W) ? PC_W : GC_W) + 1;
   localparam int OFS_W   = ((SIZE_W > CNT_W) ? SIZE_W : CNT_W) + 1;

   logic [CNT_W-1:0]   col_ff, col_in;
   logic [CNT_W-1:0]   row_ff, row_in;
   logic [PC_W-1:0]    pitch_wide, height_wide;
   logic [PITCH_W-1:0] height;
   logic [GC_W-1:0]    width_wide, rows_wide;
   logic [GC_W-1:0]    gw, gr;
   logic [SIZE_W-2:0]  ox_mag, oy_mag;
   logic [BND_W-1:0]   x_end, y_end;
   logic [OFS_W-1:0]   x_sum, y_sum;
   logic               col_last, row_last;

   assign pitch_wide  = PC_W'(line_pitch);
   assign height_wide = PC_W'(buffer_height);
   assign width_wide  = GC_W'(glyph_width);
   assign rows_wide   = GC_W'(glyph_rows);

   // A size of zero counts as one; larger sizes saturate at the configured maximum.
   assign pitch  = (pitch_wide == '0) ? PITCH_W'(1) :
                   (pitch_wide > PC_W'(MAX_PITCH)) ? PITCH_W'(MAX_PITCH) :
                   PITCH_W'(pitch_wide);
   assign height = (height_wide == '0) ? PITCH_W'(1) :
                   (height_wide > PC_W'(MAX_PITCH)) ? PITCH_W'(MAX_PITCH) :
                   PITCH_W'(height_wide);
   assign gw     = (width_wide == '0) ? GC_W'(1) :
                   (width_wide > GC_W'(MAX_GLYPH)) ? GC_W'(MAX_GLYPH) : width_wide;
   assign gr     = (rows_wide == '0) ? GC_W'(1) :
                   (rows_wide > GC_W'(MAX_GLYPH)) ? GC_W'(MAX_GLYPH) : rows_wide;

   assign ox_mag = origin_x[SIZE_W-2:0];
   assign oy_mag = origin_y[SIZE_W-2:0];
   assign x_end  = BND_W'(ox_mag) + BND_W'(gw);
   assign y_end  = BND_W'(oy_mag) + BND_W'(gr);

   assign place.in_bounds = !origin_x[SIZE_W-1] && !origin_y[SIZE_W-1] &&
                            (x_end <= BND_W'(pitch)) && (y_end <= BND_W'(height));

   // A counter at or past its final position, after a size change, still wraps.
   assign col_last   = (GC_W'(col_ff) + GC_W'(1)) >= gw;
   assign row_last   = (GC_W'(row_ff) + GC_W'(1)) >= gr;
   assign place.last = col_last && row_last;

   assign x_sum   = OFS_W'(ox_mag) + OFS_W'(col_ff);
   assign y_sum   = OFS_W'(oy_mag) + OFS_W'(row_ff);
   assign col_pos = POS_W'(x_sum);
   assign row_pos = POS_W'(y_sum);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (advance) begin
         if (col_last) begin
            col_in = '0;
            row_in = row_last ? '0 : row_ff + CNT_W'(1);
         end else begin
            col_in = col_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

/* design/gcb_blend.sv */
// Per-channel gamma blend of foreground over background with rounded divide by 255.
module gcb_blend (
   input  logic                        clock,
   input  logic                        load,
   input  logic [gcb_pkg::CH_W-1:0]    gamma,
   input  logic [gcb_pkg::RGB_W-1:0]   fg_rgb,
   input  logic [gcb_pkg::RGB_W-1:0]   bg_rgb,
   output logic [gcb_pkg::RGB_W-1:0]   rgb
);
   import gcb_pkg::*;

   logic [BLEND_W-1:0] sum_ff [CHANNELS];
   logic [BLEND_W-1:0] sum_in [CHANNELS];
   logic [CH_W-1:0]    inv_gamma;

   assign inv_gamma = CH_MAX - gamma;

   for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
      logic [BLEND_W-1:0] fg_term, bg_term;
      logic [BLEND_W:0]   rounded, scaled;

      assign fg_term   = BLEND_W'(gamma) * BLEND_W'(fg_rgb[CH_W*c +: CH_W]);
      assign bg_term   = BLEND_W'(inv_gamma) * BLEND_W'(bg_rgb[CH_W*c +: CH_W]);
      assign sum_in[c] = fg_term + bg_term;

      always_ff @(posedge clock) begin
         if (load) begin
            sum_ff[c] <= sum_in[c];
         end
      end

      // Rounded n/255 is floor((n + 127) / 255); with y = n + 128 that is
      // (y + y/256) / 256, exact over the whole 16-bit range.
      assign rounded = (BLEND_W + 1)'(sum_ff[c]) + (BLEND_W + 1)'(128);
      assign scaled  = rounded + (rounded >> 8);
      assign rgb[CH_W*c +: CH_W] = scaled[2*CH_W-1:CH_W];
   end

endmodule
